// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the node update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/enmu_pkg.sv
// Package of constants and codes for the explicit node motion update block.
`timescale 1ns / 1ps
package enmu_pkg;

  // Default node count
  localparam int unsigned NodesDef = 1024;

  // Field widths
  localparam int unsigned NodeW  = 10;
  localparam int unsigned AxisW  = 2;
  localparam int unsigned MassW  = 40;
  localparam int unsigned QW     = 48;
  localparam int unsigned CfgAW  = 3;
  localparam int unsigned InDW   = 248;
  localparam int unsigned OutDW  = 112;

  // Q24.24 limits
  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CfgAW-1:0] {
    REG_TIME_STEP = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_MASS_THR  = 3'd2,
    REG_GRAV_X    = 3'd3,
    REG_GRAV_Y    = 3'd4,
    REG_GRAV_Z    = 3'd5
  } cfg_reg_e;

  // Axis codes
  localparam logic [AxisW-1:0] AxisX = 2'd0;
  localparam logic [AxisW-1:0] AxisY = 2'd1;
  localparam logic [AxisW-1:0] AxisZ = 2'd2;

  // Products formed by the shared multiplier
  typedef enum logic [2:0] {
    OP_DM   = 3'd0,
    OP_BA   = 3'd1,
    OP_DAMP = 3'd2,
    OP_GRAV = 3'd3,
    OP_DV   = 3'd4,
    OP_POS  = 3'd5
  } mul_op_e;

  // Reset values of the registers
  localparam logic [MassW-1:0] TimeStepRst = 40'd1678;
  localparam logic [MassW-1:0] DampingRst  = 40'd40223375;
  localparam logic [MassW-1:0] MassThrRst  = 40'd1;

endpackage

// File: rtl/core/explicit_node_motion_update.sv
// Top level of the explicit central-difference node update with its state memory.
//
// One request updates one axis of one node: force, velocity and position of
// that axis live in one synchronous memory of 3*NODES words, read, modified
// and written back per request. A new request is taken only once the block
// has returned to idle. The full path is set by up to six 48-bit products
// through one shared 24x24 multiplier and a restoring divider that first
// loads the dividend and then forms one quotient bit per cycle. The result is
// presented as the block returns to idle; the final cycle of an item is held
// for as long as the previous result still waits in the output register.
// After reset a clearing pass zeroes all 3*NODES words of the memory before
// the first request is taken. A finished result waits in the output register
// while the next request is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module explicit_node_motion_update
  import enmu_pkg::*;
#(
  parameter int unsigned NODES = NodesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write port
  input  logic             cfg_we_i,
  input  logic [CfgAW-1:0] cfg_addr_i,
  input  logic [QW-1:0]    cfg_wdata_i,
  // Request stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // low to high: node, mass, contact_force, body_force, body_accel,
  // velocity_fixed, supplied_velocity, removed, gravity_scale, zero_force,
  // freeze_mode, one zero pad bit
  input  logic [InDW-1:0]  s_axis_tdata,
  // axis
  input  logic [AxisW-1:0] s_axis_tuser,
  // Result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // low to high: out_node, velocity, position, updated, five zero pad bits
  output logic [OutDW-1:0] m_axis_tdata,
  // out_axis
  output logic [AxisW-1:0] m_axis_tuser
);

  localparam int unsigned Depth = 3 * NODES;
  localparam int unsigned EW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned MemW  = 3 * QW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_LOAD  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_MDONE = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  // Configuration registers
  logic [MassW-1:0]     tstep_q, damp_q, mthr_q;
  logic signed [QW-1:0] gx_q, gy_q, gz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstep_q <= TimeStepRst;
      damp_q  <= DampingRst;
      mthr_q  <= MassThrRst;
      gx_q    <= '0;
      gy_q    <= '0;
      gz_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TIME_STEP: tstep_q <= cfg_wdata_i[MassW-1:0];
        REG_DAMPING:   damp_q  <= cfg_wdata_i[MassW-1:0];
        REG_MASS_THR:  mthr_q  <= cfg_wdata_i[MassW-1:0];
        REG_GRAV_X:    gx_q    <= cfg_wdata_i;
        REG_GRAV_Y:    gy_q    <= cfg_wdata_i;
        REG_GRAV_Z:    gz_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state
  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  logic [2:0]    mcnt_q, mcnt_d;
  logic [EW-1:0] clr_q, clr_d;
  logic [6:0]    dcnt_q, dcnt_d;
  logic          ov_q, ov_d;

  // Request fields
  logic [NodeW-1:0]     node_q, node_d;
  logic [AxisW-1:0]     axis_q, axis_d;
  logic [MassW-1:0]     mass_q, mass_d;
  logic signed [QW-1:0] cont_q, cont_d, bf_q, bf_d, ba_q, ba_d, sup_q, sup_d;
  logic fix_q, fix_d, rem_q, rem_d, gs_q, gs_d, zf_q, zf_d, frz_q, frz_d;

  // Datapath
  logic [QW-1:0]        mx_q, mx_d, my_q, my_d, prod_q, prod_d, dm_q, dm_d;
  logic                 mneg_q, mneg_d, upd_q, upd_d;
  logic [95:0]          acc_q, acc_d;
  logic signed [QW-1:0] vold_q, vold_d, pold_q, pold_d, fnew_q, fnew_d;
  logic signed [QW-1:0] vnew_q, vnew_d, pnew_q, pnew_d;
  logic signed [QW+2:0] sum_q, sum_d;
  logic [MassW-1:0]     drem_q, drem_d;
  logic [QW-1:0]        dquo_q, dquo_d;
  logic                 dover_q, dover_d, dneg_q, dneg_d;
  logic [71:0]          dvd_q, dvd_d;

  // Output register
  logic [NodeW-1:0]     on_q, on_d;
  logic [AxisW-1:0]     oa_q, oa_d;
  logic signed [QW-1:0] ovel_q, ovel_d, opos_q, opos_d;
  logic                 oupd_q, oupd_d;

  // State memory: {position, velocity, force}
  logic [MemW-1:0] mem [Depth];
  logic [MemW-1:0] rd_q, mem_wd;
  logic [EW-1:0]   mem_wa, ent;
  logic            mem_we;
  logic [17:0]     ent_w;

  assign ent_w = {7'd0, node_q, 1'b0} + {8'd0, node_q} + {16'd0, axis_q};
  assign ent   = ent_w[EW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[ent];
  end

  // Shared 24x24 multiplier operand selection
  logic [23:0] pa, pb;
  logic [QW-1:0] pprod;
  logic [95:0] pshift;
  always_comb begin
    case (mcnt_q)
      3'd0:    begin pa = mx_q[23:0];  pb = my_q[23:0];  end
      3'd1:    begin pa = mx_q[47:24]; pb = my_q[23:0];  end
      3'd2:    begin pa = mx_q[23:0];  pb = my_q[47:24]; end
      default: begin pa = mx_q[47:24]; pb = my_q[47:24]; end
    endcase
    case (mcnt_q)
      3'd1:    pshift = {48'd0, prod_q};
      3'd4:    pshift = {prod_q, 48'd0};
      default: pshift = {24'd0, prod_q, 24'd0};
    endcase
  end
  assign pprod = pa * pb;

  // Round half away from zero, saturate and restore the sign
  logic [72:0]          rnd;
  logic [QW-1:0]        mlim, mres;
  logic signed [QW-1:0] sres;
  assign rnd  = {1'b0, acc_q[95:24]} + {72'd0, acc_q[23]};
  assign mlim = mneg_q ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  assign mres = (rnd > {25'd0, mlim}) ? mlim : rnd[QW-1:0];
  assign sres = mneg_q ? -$signed(mres) : $signed(mres);

  // Divider step
  logic [MassW:0] rsh, rsub;
  logic           dge;
  logic [QW:0]    qn, dlim;
  assign rsh  = {drem_q, dvd_q[71]};
  assign dge  = rsh >= {1'b0, mass_q};
  assign rsub = rsh - {1'b0, mass_q};
  assign qn   = {dquo_q, dge};
  assign dlim = dneg_q ? {2'b01, {(QW-1){1'b0}}} : {2'b00, {(QW-1){1'b1}}};

  // Combinational helpers
  logic signed [QW-1:0] fold, grav, sumsat, vsel, vfin;
  logic signed [QW:0]   vsum, psum;
  logic signed [QW+2:0] sum_n;
  logic                 skip;

  assign fold = rd_q[QW-1:0];
  always_comb begin
    case (axis_q)
      AxisX:   grav = gx_q;
      AxisY:   grav = gy_q;
      default: grav = gz_q;
    endcase
  end
  assign skip = ({22'd0, node_q} >= 32'(NODES)) || (axis_q == 2'd3) || rem_q ||
                (mass_q < mthr_q);
  assign sum_n = (op_q == OP_DAMP) ? sum_q - (QW+3)'(sres) : sum_q + (QW+3)'(sres);
  assign sumsat = (sum_q > (QW+3)'(QMax)) ? QMax :
                  (sum_q < (QW+3)'(QMin)) ? QMin : sum_q[QW-1:0];
  assign vsum = (QW+1)'(vold_q) + (QW+1)'(sres);
  assign psum = (QW+1)'(pold_q) + (QW+1)'(sres);
  assign vsel = (vsum > (QW+1)'(QMax)) ? QMax :
                (vsum < (QW+1)'(QMin)) ? QMin : vsum[QW-1:0];
  assign vfin = (frz_q && !gs_q) ? '0 : (fix_q ? sup_q : vsel);

  function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] a);
    mag = a[QW-1] ? QW'(-a) : QW'(a);
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q; op_d = op_q; mcnt_d = mcnt_q; clr_d = clr_q; dcnt_d = dcnt_q;
    ov_d = ov_q;
    node_d = node_q; axis_d = axis_q; mass_d = mass_q; cont_d = cont_q; bf_d = bf_q;
    ba_d = ba_q; sup_d = sup_q; fix_d = fix_q; rem_d = rem_q; gs_d = gs_q; zf_d = zf_q;
    frz_d = frz_q;
    mx_d = mx_q; my_d = my_q; mneg_d = mneg_q; prod_d = prod_q; acc_d = acc_q;
    dm_d = dm_q; upd_d = upd_q; vold_d = vold_q; pold_d = pold_q; fnew_d = fnew_q;
    vnew_d = vnew_q; pnew_d = pnew_q; sum_d = sum_q;
    drem_d = drem_q; dquo_d = dquo_q; dover_d = dover_q; dneg_d = dneg_q; dvd_d = dvd_q;
    on_d = on_q; oa_d = oa_q; ovel_d = ovel_q; opos_d = opos_q; oupd_d = oupd_q;
    mem_we = 1'b0; mem_wa = ent; mem_wd = {pnew_q, vnew_q, zf_q ? {QW{1'b0}} : fnew_q};

    // Release the output register once taken
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == EW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          node_d = s_axis_tdata[9:0];
          mass_d = s_axis_tdata[49:10];
          cont_d = s_axis_tdata[97:50];
          bf_d   = s_axis_tdata[145:98];
          ba_d   = s_axis_tdata[193:146];
          fix_d  = s_axis_tdata[194];
          sup_d  = s_axis_tdata[242:195];
          rem_d  = s_axis_tdata[243];
          gs_d   = s_axis_tdata[244];
          zf_d   = s_axis_tdata[245];
          frz_d  = s_axis_tdata[246];
          axis_d = s_axis_tuser;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        upd_d = !skip;
        state_d = skip ? S_DONE : S_LOAD;
      end
      S_LOAD: begin
        vold_d = rd_q[2*QW-1:QW];
        pold_d = rd_q[3*QW-1:2*QW];
        sum_d  = (QW+3)'(fold) + (QW+3)'(bf_q) + (QW+3)'(cont_q);
        mcnt_d = '0;
        acc_d  = '0;
        state_d = S_MUL;
        if (fix_q || (mass_q == '0)) begin
          // Fixed axis or zero mass: no force, no velocity increment
          fnew_d = '0;
          mx_d = '0; my_d = {8'd0, tstep_q}; mneg_d = 1'b0;
          op_d = OP_DV;
        end else begin
          mx_d = {8'd0, damp_q}; my_d = {8'd0, mass_q}; mneg_d = 1'b0;
          op_d = OP_DM;
        end
      end
      S_MUL: begin
        prod_d = pprod;
        if (mcnt_q != 3'd0) begin
          acc_d = acc_q + pshift;
        end
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 3'd4) begin
          state_d = S_MDONE;
        end
      end
      S_MDONE: begin
        mcnt_d = '0;
        acc_d  = '0;
        state_d = S_MUL;
        case (op_q)
          OP_DM: begin
            dm_d = mres;
            mx_d = mag(ba_q); my_d = {8'd0, mass_q}; mneg_d = ba_q[QW-1];
            op_d = OP_BA;
          end
          OP_BA: begin
            sum_d = sum_n;
            mx_d = mag(vold_q); my_d = dm_q; mneg_d = vold_q[QW-1];
            op_d = OP_DAMP;
          end
          OP_DAMP: begin
            sum_d = sum_n;
            if (gs_q) begin
              mx_d = mag(grav); my_d = {8'd0, mass_q}; mneg_d = grav[QW-1];
              op_d = OP_GRAV;
            end else begin
              state_d = S_DIV;
            end
          end
          OP_GRAV: begin
            sum_d = sum_n;
            state_d = S_DIV;
          end
          OP_DV: begin
            vnew_d = vfin;
            mx_d = mag(vfin); my_d = {8'd0, tstep_q}; mneg_d = vfin[QW-1];
            op_d = OP_POS;
          end
          default: begin
            pnew_d = (psum > (QW+1)'(QMax)) ? QMax :
                     (psum < (QW+1)'(QMin)) ? QMin : psum[QW-1:0];
            state_d = S_DONE;
          end
        endcase
        // Prime the divider on the way out
        if (state_d == S_DIV) begin
          dcnt_d  = '0;
          drem_d  = '0;
          dquo_d  = '0;
          dover_d = 1'b0;
        end
      end
      S_DIV: begin
        if (dcnt_q == 7'd0) begin
          // First cycle: latch the saturated force
          fnew_d = sumsat;
          dneg_d = sumsat[QW-1];
          dvd_d  = {mag(sumsat), 24'd0};
          dcnt_d = 7'd1;
        end else begin
          drem_d = dge ? rsub[MassW-1:0] : rsh[MassW-1:0];
          dvd_d  = {dvd_q[70:0], 1'b0};
          if (dover_q || (qn > dlim)) begin
            dquo_d  = dlim[QW-1:0];
            dover_d = 1'b1;
          end else begin
            dquo_d = qn[QW-1:0];
          end
          dcnt_d = dcnt_q + 1'b1;
          if (dcnt_q == 7'd72) begin
            // Feed the quotient magnitude into the velocity product
            state_d = S_MUL;
            op_d    = OP_DV;
            mcnt_d  = '0;
            acc_d   = '0;
            mx_d    = dquo_d;
            my_d    = {8'd0, tstep_q};
            mneg_d  = dneg_q && (dquo_d != '0);
          end
        end
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          mem_we = upd_q;
          ov_d   = 1'b1;
          on_d   = node_q;
          oa_d   = axis_q;
          oupd_d = upd_q;
          ovel_d = upd_q ? vnew_q : '0;
          opos_d = upd_q ? pnew_q : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= OP_DM;
      mcnt_q  <= '0;
      clr_q   <= '0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
      dover_q <= 1'b0;
      dquo_q  <= '0;
      drem_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      mcnt_q  <= mcnt_d;
      clr_q   <= clr_d;
      dcnt_q  <= dcnt_d;
      ov_q    <= ov_d;
      dover_q <= dover_d;
      dquo_q  <= dquo_d;
      drem_q  <= drem_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    node_q <= node_d; axis_q <= axis_d; mass_q <= mass_d; cont_q <= cont_d;
    bf_q <= bf_d; ba_q <= ba_d; sup_q <= sup_d; fix_q <= fix_d; rem_q <= rem_d;
    gs_q <= gs_d; zf_q <= zf_d; frz_q <= frz_d;
    mx_q <= mx_d; my_q <= my_d; mneg_q <= mneg_d; prod_q <= prod_d; acc_q <= acc_d;
    dm_q <= dm_d; upd_q <= upd_d; vold_q <= vold_d; pold_q <= pold_d;
    fnew_q <= fnew_d; vnew_q <= vnew_d; pnew_q <= pnew_d; sum_q <= sum_d;
    dneg_q <= dneg_d; dvd_q <= dvd_d;
    on_q <= on_d; oa_q <= oa_d; ovel_q <= ovel_d; opos_q <= opos_d; oupd_q <= oupd_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'd0, oupd_q, opos_q, ovel_q, on_q};
  assign m_axis_tuser  = oa_q;

  `ASSERT_CLK(a_clear_blocks_input, (state_q == S_CLEAR) |-> !s_axis_tready, "input taken during clear")
  `ASSERT_CLK(a_write_only_at_end, mem_we |-> (state_q == S_CLEAR || state_q == S_DONE), "stray memory write")
  `ASSERT_CLK(a_div_count_bound, (state_q == S_DIV) |-> (dcnt_q <= 7'd72), "divider overran")
  `ASSERT_NEVER(a_skip_zero_result, ov_q && !oupd_q && (ovel_q != '0 || opos_q != '0), "skipped result not zero")

endmodule

// File: tb/tb.sv
// Testbench for the explicit node motion update block: random requests, bit-true prediction.
`timescale 1ns / 1ps
module tb;
  import enmu_pkg::*;

  localparam int unsigned NumNodes = NodesDef;
  localparam logic [47:0] QLim = 48'h8000_0000_0000;
  localparam logic [47:0] QTop = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic              freeze;
    logic              zero_f;
    logic              gscale;
    logic              removed;
    logic signed [47:0] supplied;
    logic              fixed;
    logic signed [47:0] baccel;
    logic signed [47:0] bforce;
    logic signed [47:0] contact;
    logic [39:0]       mass;
    logic [9:0]        node;
  } upd_req_t;

  typedef struct packed {
    logic [9:0]         node;
    logic [1:0]         axis;
    logic signed [47:0] vel;
    logic signed [47:0] pos;
    logic               updated;
  } upd_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgAW-1:0] cfg_addr_i = '0;
  logic [QW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDW-1:0] s_axis_tdata = '0;
  logic [AxisW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDW-1:0] m_axis_tdata;
  logic [AxisW-1:0] m_axis_tuser;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  explicit_node_motion_update i_dut (.*);

  // Unsigned Q.24 product, rounded half up, saturated to lim
  function automatic logic [47:0] umul_q24(logic [47:0] x, logic [47:0] y, logic [47:0] lim);
    logic [96:0] p;
    p = {1'b0, x} * {49'd0, y} + 97'd8388608;
    p = p >> 24;
    return (p > {49'd0, lim}) ? lim : p[47:0];
  endfunction

  function automatic logic signed [47:0] smul_q24(logic signed [47:0] a, logic [47:0] b);
    logic neg;
    logic [47:0] mag, r;
    neg = a[47];
    mag = neg ? -a : a;
    r = umul_q24(mag, b, neg ? QLim : QTop);
    return neg ? -r : r;
  endfunction

  function automatic logic signed [47:0] sat_q24(logic signed [63:0] s);
    if (s > 64'sh7FFF_FFFF_FFFF) return QTop;
    if (s < -64'sh8000_0000_0000) return QLim;
    return s[47:0];
  endfunction

  // Force over mass, truncated toward zero, saturated
  function automatic logic signed [47:0] div_q24(logic signed [47:0] f, logic [39:0] m);
    logic neg;
    logic [47:0] mag;
    logic [71:0] q;
    neg = f[47];
    mag = neg ? -f : f;
    q = {mag, 24'd0} / m;
    if (q > {24'd0, neg ? QLim : QTop}) q = {24'd0, neg ? QLim : QTop};
    return neg ? -q[47:0] : q[47:0];
  endfunction

  class node_motion_sb;
    logic [39:0] dt, damp, thr;
    logic signed [47:0] grav [3];
    logic signed [47:0] force_mem [3*NumNodes];
    logic signed [47:0] vel_mem [3*NumNodes];
    logic signed [47:0] pos_mem [3*NumNodes];
    upd_res_t pending [$];
    int errors;

    function new();
      dt = TimeStepRst; damp = DampingRst; thr = MassThrRst;
      foreach (grav[i]) grav[i] = '0;
      foreach (force_mem[i]) begin
        force_mem[i] = '0; vel_mem[i] = '0; pos_mem[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [47:0] v);
      case (r)
        REG_TIME_STEP: dt = v[39:0];
        REG_DAMPING:   damp = v[39:0];
        REG_MASS_THR:  thr = v[39:0];
        REG_GRAV_X:    grav[0] = v;
        REG_GRAV_Y:    grav[1] = v;
        default:       grav[2] = v;
      endcase
    endfunction

    // Note an accepted request and queue its predicted result
    function void note_request(upd_req_t q, logic [1:0] ax);
      upd_res_t r;
      int e;
      logic signed [47:0] dv, v, dm;
      logic signed [63:0] sum;
      r = '0; r.node = q.node; r.axis = ax;
      dv = '0;
      if (q.node < NumNodes && ax <= AxisZ && !q.removed && q.mass >= thr) begin
        e = q.node * 3 + ax;
        if (q.fixed || q.mass == 0) begin
          force_mem[e] = '0;
        end else begin
          dm = umul_q24({8'd0, damp}, {8'd0, q.mass}, QTop);
          sum = 64'(force_mem[e]) + 64'(q.bforce) + 64'(q.contact)
              + 64'(smul_q24(q.baccel, {8'd0, q.mass})) - 64'(smul_q24(vel_mem[e], dm));
          if (q.gscale) sum += 64'(smul_q24(grav[ax], {8'd0, q.mass}));
          force_mem[e] = sat_q24(sum);
          dv = div_q24(force_mem[e], q.mass);
        end
        if (q.zero_f) force_mem[e] = '0;
        v = sat_q24(64'(vel_mem[e]) + 64'(smul_q24(dv, {8'd0, dt})));
        if (q.fixed) v = q.supplied;
        if (q.freeze && !q.gscale) v = '0;
        vel_mem[e] = v;
        pos_mem[e] = sat_q24(64'(pos_mem[e]) + 64'(smul_q24(v, {8'd0, dt})));
        r.vel = v; r.pos = pos_mem[e]; r.updated = 1'b1;
      end
      pending.push_back(r);
    endfunction

    // Compare a result with the oldest prediction
    function void check_result(logic [OutDW-1:0] d, logic [1:0] ax);
      upd_res_t got, exp_r;
      got.node = d[9:0]; got.vel = d[57:10]; got.pos = d[105:58];
      got.updated = d[106]; got.axis = ax;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r || d[111:107] !== 5'd0) begin
        errors++;
        if (errors <= 10) $display("mismatch exp %p got %p", exp_r, got);
      end
    endfunction
  endclass

  node_motion_sb sb = new();
  int rx_gap_max = 3;
  bit rx_run = 1'b0;

  // Result side: random stalls, check on each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= rx_run ? 1'b1 : ($urandom_range(0, rx_gap_max) == 0);
  end

  function automatic logic [47:0] rand48();
    case ($urandom_range(0, 5))
      0: return QTop;
      1: return QLim;
      2: return {{32{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      3: return 48'($signed(32'($urandom)) >>> $urandom_range(0, 20));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic send_req(upd_req_t q, logic [1:0] ax);
    int gap;
    // Wait before raising valid so the drop of the last request and the next raise differ
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
    if (rx_run) gap = 1;
    repeat (gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, q};
    s_axis_tuser <= ax;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(q, ax);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(cfg_reg_e r, logic [47:0] v);
    int w;
    w = 0;
    while (sb.pending.size() != 0 && w < 200000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (130) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_addr_i <= r; cfg_wdata_i <= v;
    sb.write_reg(r, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic upd_req_t rand_req(int nmax);
    upd_req_t q;
    q.node = 10'($urandom_range(0, nmax));
    q.mass = ($urandom_range(0, 3) == 0) ? {8'($urandom), 32'($urandom)}
                                        : 40'($urandom_range(1, 32'h0400_0000));
    q.contact = rand48(); q.bforce = rand48(); q.baccel = rand48();
    q.supplied = rand48();
    q.fixed = ($urandom_range(0, 4) == 0);
    q.removed = ($urandom_range(0, 9) == 0);
    q.gscale = 1'($urandom_range(0, 1));
    q.zero_f = 1'($urandom_range(0, 1));
    q.freeze = ($urandom_range(0, 3) == 0);
    return q;
  endfunction

  initial begin
    upd_req_t q;
    int w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, skip cases, fixed axis, zero mass, freeze
    q = '0; q.node = 10'd1023; q.mass = '1; q.contact = QTop; q.bforce = QTop;
    q.baccel = QTop; send_req(q, AxisX);
    q.contact = QLim; q.bforce = QLim; q.baccel = QLim; send_req(q, AxisX);
    q = '0; q.node = 10'd5; q.mass = 40'd16777216; q.contact = 48'd16777216;
    send_req(q, AxisY);
    send_req(q, AxisY);
    q.zero_f = 1'b1; send_req(q, AxisZ);
    q.fixed = 1'b1; q.supplied = QLim; send_req(q, AxisZ);
    q.fixed = 1'b0; q.freeze = 1'b1; send_req(q, AxisY);
    q.gscale = 1'b1; send_req(q, AxisY);
    q.removed = 1'b1; send_req(q, AxisX);
    q.removed = 1'b0; q.mass = '0; send_req(q, AxisX);
    q.mass = 40'd1; send_req(q, 2'd3);
    q.supplied = QTop; q.fixed = 1'b1; send_req(q, AxisX);

    write_reg(REG_MASS_THR, 48'd0);
    q = '0; q.node = 10'd7; q.mass = '0; q.contact = 48'd100; send_req(q, AxisX);
    q.fixed = 1'b1; q.supplied = 48'd12345; send_req(q, AxisX);

    // Random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TIME_STEP, 48'hFF_FFFF_FFFF);
          write_reg(REG_DAMPING, 48'hFF_FFFF_FFFF);
          write_reg(REG_GRAV_X, QTop); write_reg(REG_GRAV_Y, QLim);
          write_reg(REG_GRAV_Z, 48'hFFFF_FF00_0000);
        end
        1: begin
          write_reg(REG_TIME_STEP, 48'd0); write_reg(REG_DAMPING, 48'd0);
          write_reg(REG_MASS_THR, 48'hFF_FFFF_FFFF);
        end
        2: begin
          write_reg(REG_TIME_STEP, 48'd1 << 20); write_reg(REG_DAMPING, 48'd1 << 22);
          write_reg(REG_MASS_THR, 48'd1 << 12);
        end
        default: begin
          write_reg(REG_TIME_STEP, 48'($urandom_range(0, 1 << 24)));
          write_reg(REG_DAMPING, 48'($urandom));
          write_reg(REG_MASS_THR, 48'($urandom_range(0, 1 << 16)));
          write_reg(REG_GRAV_X, rand48()); write_reg(REG_GRAV_Y, rand48());
          write_reg(REG_GRAV_Z, rand48());
        end
      endcase
      rx_run = (ph == 3);
      rx_gap_max = (ph == 4) ? 40 : 3;
      // Few nodes so that state accumulates across requests
      for (int i = 0; i < 250; i++) begin
        q = rand_req((i % 5 == 0) ? 1023 : 15);
        send_req(q, ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
      end
    end
    rx_run = 1'b0;

    w = 0;
    while (sb.pending.size() != 0 && w < 200000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
